@@ rtl/rgb_led_effect_engine_defines.svh @@
// Assertion macros shared by the LED effect engine RTL.
`ifndef RGB_LED_EFFECT_ENGINE_DEFINES_SVH
`define RGB_LED_EFFECT_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, held off during reset
`define RLED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, held off during reset
`define RLED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rled_pkg.sv @@
// Types, constants and the pulse level table of the RGB LED effect engine.
`default_nettype none

package rled_pkg;

  // Sine table size and derived widths
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int unsigned PHASE_PROD_W = 16 + SINE_IDX_W + 1;

  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam logic [15:0]     PHASE_STEP = 16'd3129;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [14:0] RST_SHAKE_THR  = 15'd16384;
  localparam logic [15:0] RST_SHAKE_TMO  = 16'd2000;
  localparam logic [15:0] RST_WILD_FRAME = 16'd50;
  localparam logic [15:0] RST_BASE_FRAME = 16'd200;
  localparam logic [8:0]  RST_HUE_STEP   = 9'd5;
  localparam logic [8:0]  RST_BASE_BRT   = 9'd64;
  localparam logic [8:0]  RST_WILD_BRT   = 9'd256;
  localparam logic [7:0]  RST_PULSE_PER  = 8'd30;

  localparam logic [8:0] FULL_SCALE = 9'd256;
  localparam logic [8:0] HUE_WRAP   = 9'd360;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAKE_THR  = 3'd0,
    REG_SHAKE_TMO  = 3'd1,
    REG_WILD_FRAME = 3'd2,
    REG_BASE_FRAME = 3'd3,
    REG_HUE_STEP   = 3'd4,
    REG_BASE_BRT   = 3'd5,
    REG_WILD_BRT   = 3'd6,
    REG_PULSE_PER  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_OFF   = 3'd0,
    CMD_RED   = 3'd1,
    CMD_GREEN = 3'd2,
    CMD_BLUE  = 3'd3,
    CMD_WHITE = 3'd4,
    CMD_HUE   = 3'd5,
    CMD_PULSE = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_STATIC = 2'd1,
    MODE_HUE    = 2'd2,
    MODE_PULSE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        command;
    logic [31:0]       now_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [8:0]        random_hue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Controller to datapath step strobes
  typedef struct packed {
    logic capture;
    logic decide;
    logic frame;
    logic hue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_status_t;

  typedef logic [SINE_ENTRIES-1:0][7:0] level_rom_t;

  // Pulse level per table entry: 25 + 115*(s+127)/127, s = round(127*sin),
  // sine from a Q30 Taylor series, evaluated at elaboration
  function automatic level_rom_t build_level_rom();
    level_rom_t        rom;
    longint unsigned   t;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   pos;
    longint unsigned   negs;
    longint unsigned   s;
    longint unsigned   mag;
    logic              neg;
    int                sv;
    int                k;
    int                i;
    for (k = 0; k < SINE_ENTRIES; k++) begin
      t   = 64'(4 * k);
      neg = 1'b0;
      if (t >= 64'(2 * SINE_ENTRIES)) begin
        neg = 1'b1;
        t   = t - 64'(2 * SINE_ENTRIES);
      end
      if (t > 64'(SINE_ENTRIES)) t = 64'(2 * SINE_ENTRIES) - t;
      if (3 * t == 64'(SINE_ENTRIES)) begin
        mag = 64'd64;
      end else begin
        x    = (HALFPI_Q30 * t + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        negs = 64'd0;
        for (i = 1; i <= 12; i++) begin
          term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
          if (i % 2 == 1) negs = negs + term;
          else pos = pos + term;
        end
        s   = (pos > negs) ? pos - negs : 64'd0;
        mag = (64'd127 * s + (64'd1 << 29)) >> 30;
        if (mag > 64'd127) mag = 64'd127;
      end
      sv     = neg ? -int'(mag) : int'(mag);
      rom[k] = 8'(25 + (115 * (sv + 127)) / 127);
    end
    return rom;
  endfunction

  localparam level_rom_t LEVEL_ROM = build_level_rom();

endpackage

`default_nettype wire

@@ rtl/rgb_led_effect_engine.sv @@
// Top level of the RGB LED effect engine: sequencer, datapath and checks.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | in        | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//  out     | out       | out_valid_o/out_stall_i | out_item_o (out_item_t)
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time: accept, decide, frame test, hue wheel, then scale.
// A request that yields no color goes back to idle after the hue step; one that
// yields a color goes on to the scale step, which loads it, scaled unless a pulse, out.
// A held output keeps the sequencer in the scale step, stalling the input.
// Reset is asynchronous active low and restores the config, effect and control
// registers to defaults. Config writes are accepted every cycle.
`default_nettype none
`include "rgb_led_effect_engine_defines.svh"

module rgb_led_effect_engine import rled_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  rled_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  rled_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_item_o  (out_item_o)
  );

  // A taken request keeps the input stalled while it is worked on
  `RLED_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // The scale step never overwrites a result that is still held
  `RLED_ASSERT_NOW(a_no_overwrite, dp_cmd.load_out, !out_valid_o || !out_stall_i, "result overwritten")

  // Loading the output register always presents a result
  `RLED_ASSERT_NXT(a_load_shows, dp_cmd.load_out, out_valid_o, "loaded result not shown")

endmodule

`default_nettype wire

@@ rtl/rled_ctrl.sv @@
// Step sequencer and output handshake of the LED effect engine.
`default_nettype none

module rled_ctrl import rled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_FRAME  = 5'b00100,
    ST_HUE    = 5'b01000,
    ST_SCALE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and step strobes
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_FRAME;
      end
      ST_FRAME: begin
        cmd_o.frame = 1'b1;
        state_d     = ST_HUE;
      end
      ST_HUE: begin
        cmd_o.hue = 1'b1;
        state_d   = status_i.emit ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/rled_dp.sv @@
// Datapath of the LED effect engine: registers, effect state and color math.
`default_nettype none

module rled_dp import rled_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_item_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_item_o
);

  // Brightness register value clipped to full scale
  function automatic logic [8:0] sat9(logic [8:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  function automatic logic [8:0] mod360(logic [8:0] v);
    return (v >= HUE_WRAP) ? v - HUE_WRAP : v;
  endfunction

  function automatic logic [15:0] mag16(logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    return u[15] ? (~u + 16'd1) : u;
  endfunction

  // Full saturation hue wheel, h below 360
  function automatic out_item_t hue_rgb(logic [8:0] h);
    out_item_t   c;
    logic [2:0]  sector;
    logic [8:0]  base;
    logic [5:0]  rem;
    logic [9:0]  up_p;
    logic [12:0] dn_p;
    logic [7:0]  up;
    logic [7:0]  dn;
    if (h < 9'd60) begin
      sector = 3'd0; base = 9'd0;
    end else if (h < 9'd120) begin
      sector = 3'd1; base = 9'd60;
    end else if (h < 9'd180) begin
      sector = 3'd2; base = 9'd120;
    end else if (h < 9'd240) begin
      sector = 3'd3; base = 9'd180;
    end else if (h < 9'd300) begin
      sector = 3'd4; base = 9'd240;
    end else begin
      sector = 3'd5; base = 9'd300;
    end
    rem  = 6'(h - base);
    up_p = 10'(rem) * 10'd17;
    dn_p = 13'(7'd60 - 7'(rem)) * 13'd17;
    up   = up_p[9:2];
    dn   = dn_p[9:2];
    case (sector)
      3'd0:    c = '{red: 8'hFF, green: up,    blue: 8'h00};
      3'd1:    c = '{red: dn,    green: 8'hFF, blue: 8'h00};
      3'd2:    c = '{red: 8'h00, green: 8'hFF, blue: up};
      3'd3:    c = '{red: 8'h00, green: dn,    blue: 8'hFF};
      3'd4:    c = '{red: up,    green: 8'h00, blue: 8'hFF};
      default: c = '{red: 8'hFF, green: 8'h00, blue: dn};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] scale8(logic [7:0] c, logic [8:0] s);
    logic [16:0] p;
    p = 17'(c) * 17'(s);
    return p[15:8];
  endfunction

  // Configuration registers
  logic [14:0] thr_q;
  logic [15:0] tmo_q;
  logic [15:0] wild_frame_q;
  logic [15:0] base_frame_q;
  logic [8:0]  hue_step_q;
  logic [8:0]  base_brt_q;
  logic [8:0]  wild_brt_q;
  logic [7:0]  pulse_per_q;

  // Effect state
  mode_e       mode_q;
  logic        wild_q;
  logic [8:0]  scale_q;
  logic [31:0] last_shake_q;
  logic [31:0] last_frame_q;
  logic [8:0]  hue_q;
  logic [31:0] last_pulse_q;
  logic [15:0] phase_q;

  // Per-request working registers
  in_item_t    item_q;
  logic        emit_q;
  logic        use_hue_q;
  logic        bypass_q;
  logic [8:0]  hue_sel_q;
  out_item_t   col_q;
  out_item_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= RST_SHAKE_THR;
      tmo_q        <= RST_SHAKE_TMO;
      wild_frame_q <= RST_WILD_FRAME;
      base_frame_q <= RST_BASE_FRAME;
      hue_step_q   <= RST_HUE_STEP;
      base_brt_q   <= RST_BASE_BRT;
      wild_brt_q   <= RST_WILD_BRT;
      pulse_per_q  <= RST_PULSE_PER;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SHAKE_THR:  thr_q        <= cfg_data_i[14:0];
        REG_SHAKE_TMO:  tmo_q        <= cfg_data_i;
        REG_WILD_FRAME: wild_frame_q <= cfg_data_i;
        REG_BASE_FRAME: base_frame_q <= cfg_data_i;
        REG_HUE_STEP:   hue_step_q   <= cfg_data_i[8:0];
        REG_BASE_BRT:   base_brt_q   <= cfg_data_i[8:0];
        REG_WILD_BRT:   wild_brt_q   <= cfg_data_i[8:0];
        REG_PULSE_PER:  pulse_per_q  <= cfg_data_i[7:0];
        default:        thr_q        <= thr_q;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
  end

  logic [8:0]  sat_base, sat_wild;
  logic        shake, timed_out;
  logic [31:0] since_shake, since_frame, since_pulse;
  logic        wild, frame_due, pulse_due;
  logic [15:0] interval;
  logic [9:0]  hue_sum;
  logic [8:0]  hue_adv, rnd_hue;
  logic [PHASE_PROD_W-1:0] phase_prod;
  logic [SINE_IDX_W-1:0]   sine_idx;
  logic [7:0]  level;

  // Command decode
  logic        cmd_emit, cmd_stop;
  mode_e       cmd_mode;
  out_item_t   cmd_col;

  always_comb begin
    cmd_emit = 1'b1;
    cmd_stop = 1'b1;
    cmd_mode = MODE_STATIC;
    cmd_col  = '0;
    case (cmd_e'(item_q.command))
      CMD_OFF:   cmd_mode = MODE_OFF;
      CMD_RED:   cmd_col.red = 8'hFF;
      CMD_GREEN: cmd_col.green = 8'hFF;
      CMD_BLUE:  cmd_col.blue = 8'hFF;
      CMD_WHITE: cmd_col = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
      CMD_HUE: begin
        // already cycling: ignored
        cmd_mode = MODE_HUE;
        cmd_emit = (mode_q != MODE_HUE);
        cmd_stop = (mode_q != MODE_HUE);
      end
      CMD_PULSE: cmd_mode = MODE_PULSE;
      default: begin
        cmd_emit = 1'b0;
        cmd_stop = 1'b0;
      end
    endcase
  end

  // Shake and timeout tests
  assign sat_base    = sat9(base_brt_q);
  assign sat_wild    = sat9(wild_brt_q);
  assign shake       = (mag16(item_q.accel_x) > {1'b0, thr_q}) ||
                       (mag16(item_q.accel_y) > {1'b0, thr_q}) ||
                       (mag16(item_q.accel_z) > {1'b0, thr_q});
  assign since_shake = item_q.now_ms - last_shake_q;
  assign timed_out   = wild_q && (since_shake > {16'd0, tmo_q});

  // Frame and pulse timing
  assign wild        = (scale_q == sat_wild);
  assign interval    = wild ? wild_frame_q : base_frame_q;
  assign since_frame = item_q.now_ms - last_frame_q;
  assign frame_due   = (since_frame >= {16'd0, interval});
  assign since_pulse = item_q.now_ms - last_pulse_q;
  assign pulse_due   = (since_pulse >= {24'd0, pulse_per_q});

  // Hue advance modulo 360
  assign hue_sum = {1'b0, hue_q} + {1'b0, mod360(hue_step_q)};
  assign hue_adv = (hue_sum >= {1'b0, HUE_WRAP}) ? 9'(hue_sum - {1'b0, HUE_WRAP})
                                                 : hue_sum[8:0];
  assign rnd_hue = mod360(item_q.random_hue);

  // Pulse level lookup
  assign phase_prod = PHASE_PROD_W'(phase_q) * PHASE_PROD_W'(SINE_ENTRIES);
  assign sine_idx   = phase_prod[16 +: SINE_IDX_W];
  assign level      = LEVEL_ROM[sine_idx];

  // Effect state and per-request steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      wild_q       <= 1'b0;
      scale_q      <= sat9(RST_BASE_BRT);
      last_shake_q <= '0;
      last_frame_q <= '0;
      hue_q        <= '0;
      last_pulse_q <= '0;
      phase_q      <= '0;
      emit_q       <= 1'b0;
      use_hue_q    <= 1'b0;
      bypass_q     <= 1'b0;
      hue_sel_q    <= '0;
      col_q        <= '0;
    end else begin
      if (cmd_i.decide) begin
        use_hue_q <= 1'b0;
        bypass_q  <= 1'b0;
        if (item_q.req_type == REQ_COMMAND) begin
          emit_q <= cmd_emit;
          col_q  <= cmd_col;
          if (cmd_stop) begin
            mode_q  <= cmd_mode;
            wild_q  <= 1'b0;
            scale_q <= sat_base;
            if (cmd_mode == MODE_HUE) begin
              last_shake_q <= '0;
              hue_q        <= '0;
              last_frame_q <= item_q.now_ms;
            end
            if (cmd_mode == MODE_PULSE) begin
              phase_q      <= '0;
              last_pulse_q <= item_q.now_ms;
            end
          end
        end else begin
          emit_q <= 1'b0;
          if (mode_q == MODE_HUE) begin
            if (shake) begin
              wild_q       <= 1'b1;
              last_shake_q <= item_q.now_ms;
              scale_q      <= sat_wild;
            end else if (timed_out) begin
              wild_q  <= 1'b0;
              scale_q <= sat_base;
            end
          end
        end
      end

      if (cmd_i.frame && item_q.req_type == REQ_SAMPLE) begin
        if (mode_q == MODE_HUE && frame_due) begin
          last_frame_q <= item_q.now_ms;
          emit_q       <= 1'b1;
          use_hue_q    <= 1'b1;
          hue_sel_q    <= wild ? rnd_hue : hue_q;
          if (!wild) hue_q <= hue_adv;
        end else if (mode_q == MODE_PULSE && pulse_due) begin
          last_pulse_q <= item_q.now_ms;
          phase_q      <= phase_q + PHASE_STEP;
          emit_q       <= 1'b1;
          bypass_q     <= 1'b1;
          col_q        <= '{red: level, green: 8'h00, blue: level};
        end
      end

      if (cmd_i.hue && use_hue_q) col_q <= hue_rgb(hue_sel_q);
    end
  end

  // Brightness scaling into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (bypass_q) begin
        out_q <= col_q;
      end else begin
        out_q.red   <= scale8(col_q.red, scale_q);
        out_q.green <= scale8(col_q.green, scale_q);
        out_q.blue  <= scale8(col_q.blue, scale_q);
      end
    end
  end

  assign status_o.emit = emit_q;
  assign out_item_o    = out_q;

endmodule

`default_nettype wire

@@ bench/rgb_led_effect_engine_checker.sv @@
// Checker for the LED effect engine: tracks requests, predicts colors, compares results.
module rgb_led_effect_engine_checker import rled_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam real PI = 3.14159265358979323846;

  // Register copies
  logic [14:0] shake_thr;
  logic [15:0] shake_tmo;
  logic [15:0] wild_frame;
  logic [15:0] base_frame;
  logic [8:0]  hue_step;
  logic [8:0]  base_brt;
  logic [8:0]  wild_brt;
  logic [7:0]  pulse_per;

  // Effect state
  mode_e       cur_mode;
  logic        wild_on;
  logic [8:0]  cur_scale;
  logic [31:0] shake_at;
  logic [31:0] frame_at;
  logic [8:0]  wheel_deg;
  logic [31:0] pulse_at;
  logic [15:0] pulse_phase;

  logic [7:0]  pulse_level [SINE_ENTRIES];
  out_item_t   due_colors [$];

  // Pulse levels from round(127*sin), halves away from zero
  initial begin
    real amp;
    int  s;
    fail_count_o = 0;
    pending_o    = 0;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      amp = 127.0 * $sin(2.0 * PI * k / SINE_ENTRIES);
      s = (amp >= 0.0) ? int'($floor(amp + 0.5)) : -int'($floor(0.5 - amp));
      pulse_level[k] = 8'(25 + (115 * (s + 127)) / 127);
    end
  end

  function automatic logic [8:0] clamp_scale(logic [8:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  function automatic int magnitude(logic signed [15:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // Full saturation color wheel
  function automatic out_item_t hue_color(logic [8:0] deg);
    int h;
    int rem;
    int up;
    int dn;
    h   = int'(deg) % int'(HUE_WRAP);
    rem = h % 60;
    up  = rem * 17 / 4;
    dn  = (60 - rem) * 17 / 4;
    case (h / 60)
      0:       return {8'd255, 8'(up), 8'd0};
      1:       return {8'(dn), 8'd255, 8'd0};
      2:       return {8'd0, 8'd255, 8'(up)};
      3:       return {8'd0, 8'(dn), 8'd255};
      4:       return {8'(up), 8'd0, 8'd255};
      default: return {8'd255, 8'd0, 8'(dn)};
    endcase
  endfunction

  // Brightness scaling in 256ths, rounding down
  function automatic out_item_t dim(out_item_t c);
    return {8'((int'(c.red) * int'(cur_scale)) >> 8),
            8'((int'(c.green) * int'(cur_scale)) >> 8),
            8'((int'(c.blue) * int'(cur_scale)) >> 8)};
  endfunction

  function automatic void stop_effect();
    cur_mode  = MODE_OFF;
    wild_on   = 1'b0;
    cur_scale = clamp_scale(base_brt);
  endfunction

  function automatic void set_static(out_item_t c);
    stop_effect();
    cur_mode = MODE_STATIC;
    due_colors.push_back(dim(c));
  endfunction

  // Advance the effect state for one request and queue the color it yields
  task automatic track_request(input in_item_t req);
    logic        fast;
    logic [15:0] interval;
    out_item_t   c;
    if (req.req_type == REQ_COMMAND) begin
      case (req.command)
        CMD_OFF: begin
          stop_effect();
          due_colors.push_back('0);
        end
        CMD_RED:   set_static({8'd255, 8'd0, 8'd0});
        CMD_GREEN: set_static({8'd0, 8'd255, 8'd0});
        CMD_BLUE:  set_static({8'd0, 8'd0, 8'd255});
        CMD_WHITE: set_static({8'd255, 8'd255, 8'd255});
        CMD_HUE: begin
          // a running hue cycle keeps going untouched
          if (cur_mode != MODE_HUE) begin
            stop_effect();
            cur_mode  = MODE_HUE;
            shake_at  = '0;
            wheel_deg = '0;
            frame_at  = req.now_ms;
            due_colors.push_back('0);
          end
        end
        CMD_PULSE: begin
          stop_effect();
          cur_mode    = MODE_PULSE;
          pulse_phase = '0;
          pulse_at    = req.now_ms;
          due_colors.push_back('0);
        end
        default: ;  // unused code, dropped
      endcase
    end else if (cur_mode == MODE_HUE) begin
      // shake on any axis latches wild mode
      if (magnitude(req.accel_x) > int'(shake_thr) || magnitude(req.accel_y) > int'(shake_thr) ||
          magnitude(req.accel_z) > int'(shake_thr)) begin
        wild_on   = 1'b1;
        shake_at  = req.now_ms;
        cur_scale = clamp_scale(wild_brt);
      end
      if (wild_on && (req.now_ms - shake_at) > 32'(shake_tmo)) begin
        wild_on   = 1'b0;
        cur_scale = clamp_scale(base_brt);
      end
      fast     = (cur_scale == clamp_scale(wild_brt));
      interval = fast ? wild_frame : base_frame;
      if ((req.now_ms - frame_at) >= 32'(interval)) begin
        frame_at = req.now_ms;
        if (fast) begin
          c = hue_color(req.random_hue);
        end else begin
          c = hue_color(wheel_deg);
          wheel_deg = 9'((int'(wheel_deg) + int'(hue_step)) % int'(HUE_WRAP));
        end
        due_colors.push_back(dim(c));
      end
    end else if (cur_mode == MODE_PULSE) begin
      if ((req.now_ms - pulse_at) >= 32'(pulse_per)) begin
        c.red   = pulse_level[int'((32'(pulse_phase) * SINE_ENTRIES) >> 16)];
        c.green = 8'd0;
        c.blue  = c.red;
        pulse_at    = req.now_ms;
        pulse_phase = pulse_phase + PHASE_STEP;
        due_colors.push_back(c);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      shake_thr   = RST_SHAKE_THR;
      shake_tmo   = RST_SHAKE_TMO;
      wild_frame  = RST_WILD_FRAME;
      base_frame  = RST_BASE_FRAME;
      hue_step    = RST_HUE_STEP;
      base_brt    = RST_BASE_BRT;
      wild_brt    = RST_WILD_BRT;
      pulse_per   = RST_PULSE_PER;
      stop_effect();
      shake_at    = '0;
      frame_at    = '0;
      wheel_deg   = '0;
      pulse_at    = '0;
      pulse_phase = '0;
      due_colors.delete();
      pending_o   = 0;
    end else begin
      // result side first: it can only belong to an earlier request
      if (out_valid_i && !out_stall_i) begin
        if (due_colors.size() == 0) begin
          $display("%0t: unexpected color, expected none, got r=%0d g=%0d b=%0d",
                   $time, out_item_i.red, out_item_i.green, out_item_i.blue);
          fail_count_o++;
        end else begin
          want = due_colors.pop_front();
          if (want.red !== out_item_i.red || want.green !== out_item_i.green ||
              want.blue !== out_item_i.blue) begin
            $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     out_item_i.red, out_item_i.green, out_item_i.blue);
            fail_count_o++;
          end
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_SHAKE_THR:  shake_thr  = cfg_data_i[14:0];
          REG_SHAKE_TMO:  shake_tmo  = cfg_data_i;
          REG_WILD_FRAME: wild_frame = cfg_data_i;
          REG_BASE_FRAME: base_frame = cfg_data_i;
          REG_HUE_STEP:   hue_step   = cfg_data_i[8:0];
          REG_BASE_BRT:   base_brt   = cfg_data_i[8:0];
          REG_WILD_BRT:   wild_brt   = cfg_data_i[8:0];
          REG_PULSE_PER:  pulse_per  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) track_request(in_item_i);
      pending_o = due_colors.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// Stimulus, handshakes and verdict for the RGB LED effect engine regression.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rled_pkg::*;

  localparam int         RESET_CYCLES   = 9;
  localparam int         MAX_WAIT       = 12;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 20;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         RANDOM_PHASES  = 5;
  localparam int         PHASE_ITEMS    = 125;
  localparam int         BURST_ITEMS    = 30;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit                    hold_rx;
  int                    tx_run;
  int                    rx_run;
  int                    quiet_cycles;
  logic [15:0]           cfg_plan [8];
  logic [31:0]           clock_ms;
  int                    dt_max;

  rgb_led_effect_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rgb_led_effect_engine_checker color_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Wait draw per request, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic in_item_t make_req(logic req, logic [2:0] cmd, logic [31:0] now,
                                        logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [8:0] deg);
    in_item_t it;
    it.req_type   = req;
    it.command    = cmd;
    it.now_ms     = now;
    it.accel_x    = ax;
    it.accel_y    = ay;
    it.accel_z    = az;
    it.random_hue = deg;
    return it;
  endfunction

  // Axis value above the threshold (shake) or at most the threshold
  function automatic logic [15:0] accel_draw(int thr, bit shake);
    int m;
    m = shake ? $urandom_range(thr + 1, 32768) : $urandom_range(0, thr);
    if (m == 32768) return 16'h8000;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  // Offer one request; called and returning on a falling edge
  task automatic send_req(input in_item_t it);
    int gap;
    gap = draw_wait(tx_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Write all eight registers from cfg_plan
  task automatic cfg_write_all();
    for (int r = 0; r < 8; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= cfg_plan[r];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain all expected colors, then let requests without a color finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall per color, one long hold when asked
  initial begin
    int n;
    out_stall = 1'b0;
    rx_run    = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = hold_rx ? HOLD_CYCLES : draw_wait(rx_run);
      hold_rx = 1'b0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rgb_led_effect_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_item_t    it;
    int          pick;
    logic [14:0] thr;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_rx      = 1'b0;
    tx_run       = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on reset register values
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd100, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_RED, 32'd110, 16'hFFFF, 16'h0, 16'h7FFF, 9'h1FF));
    send_req(make_req(REQ_COMMAND, CMD_GREEN, 32'd111, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_BLUE, 32'd112, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_WHITE, 32'd113, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_OFF, 32'd114, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_UNUSED, 32'd115, 16'd0, 16'd0, 16'd0, 9'd0));
    // hue cycle start, then a repeated start that is dropped
    send_req(make_req(REQ_COMMAND, CMD_HUE, 32'd1000, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_HUE, 32'd1005, 16'd0, 16'd0, 16'd0, 9'd0));
    // threshold itself is no shake; frame due exactly on the interval
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1199, 16'd16384, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1200, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1400, 16'd0, 16'hC000, 16'd0, 9'd0));
    // shakes latch wild mode; hue above 359 wraps
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1410, 16'h8000, 16'd0, 16'd0, 9'd10));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1460, 16'd0, 16'd0, 16'd0, 9'd359));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1510, 16'd0, 16'h7FFF, 16'd0, 9'd511));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd1560, 16'd0, 16'd0, 16'd16385, 9'd300));
    // timeout returns to base brightness
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'd3561, 16'd0, 16'd0, 16'd0, 9'd0));
    // pulse across the 32-bit time wrap
    send_req(make_req(REQ_COMMAND, CMD_PULSE, 32'hFFFF_FFF0, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'hFFFF_FFFD, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'h0000_000E, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'h0000_002C, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'h0000_004A, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_COMMAND, CMD_HUE, 32'hFFFF_FF00, 16'd0, 16'd0, 16'd0, 9'd0));
    send_req(make_req(REQ_SAMPLE, CMD_OFF, 32'h0000_0010, 16'd0, 16'd0, 16'd0, 9'd0));

    // Random phases, each on its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          foreach (cfg_plan[r]) cfg_plan[r] = '0;
          dt_max = 5;
        end
        1: begin
          cfg_plan = '{16'd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd359, 16'd256, 16'd256,
                       16'd255};
          dt_max = 70000;
        end
        2: begin
          cfg_plan = '{16'd12000, 16'd300, 16'd20, 16'd60, 16'h01FF, 16'hFFFF, 16'd100,
                       16'd1};
          dt_max = 80;
        end
        3: begin
          cfg_plan[REG_SHAKE_THR]  = 16'($urandom_range(2000, 30000));
          cfg_plan[REG_SHAKE_TMO]  = 16'($urandom_range(50, 1000));
          cfg_plan[REG_WILD_FRAME] = 16'($urandom_range(5, 60));
          cfg_plan[REG_BASE_FRAME] = 16'($urandom_range(20, 200));
          cfg_plan[REG_HUE_STEP]   = 16'($urandom_range(0, 511));
          cfg_plan[REG_BASE_BRT]   = 16'($urandom_range(0, 300));
          cfg_plan[REG_WILD_BRT]   = 16'($urandom_range(0, 300));
          cfg_plan[REG_PULSE_PER]  = 16'($urandom_range(1, 60));
          dt_max = 150;
        end
        default: begin
          foreach (cfg_plan[r]) cfg_plan[r] = 16'($urandom);
          dt_max = 70000;
        end
      endcase
      cfg_write_all();
      thr      = cfg_plan[REG_SHAKE_THR][14:0];
      clock_ms = $urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'($urandom);

      // long receiver hold while static colors keep coming
      if (ph == 3) begin
        hold_rx = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++)
          send_req(make_req(REQ_COMMAND, 3'($urandom_range(0, 4)), clock_ms,
                            16'($urandom), 16'($urandom), 16'($urandom), 9'($urandom)));
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        it = make_req(REQ_SAMPLE, 3'($urandom), clock_ms, accel_draw(thr, 1'b0),
                      accel_draw(thr, 1'b0), accel_draw(thr, 1'b0), 9'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // mostly effects that run on samples
          it.req_type = REQ_COMMAND;
          pick = $urandom_range(0, 99);
          if (pick < 35)      it.command = CMD_HUE;
          else if (pick < 60) it.command = CMD_PULSE;
          else if (pick < 68) it.command = CMD_UNUSED;
          else                it.command = 3'($urandom_range(0, 4));
        end else begin
          if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
          else clock_ms = clock_ms + 32'($urandom_range(0, dt_max));
          it.now_ms = clock_ms;
          case ($urandom_range(0, 19))
            0: begin
              it.accel_x = 16'($urandom);
              it.accel_y = 16'($urandom);
              it.accel_z = 16'($urandom);
            end
            1, 2: begin
              case ($urandom_range(0, 2))
                0:       it.accel_x = accel_draw(thr, 1'b1);
                1:       it.accel_y = accel_draw(thr, 1'b1);
                default: it.accel_z = accel_draw(thr, 1'b1);
              endcase
            end
            default: ;
          endcase
        end
        send_req(it);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("rgb_led_effect_engine regression: pass");
    end else begin
      $display("rgb_led_effect_engine regression: fail");
    end
    $finish;
  end

endmodule
